>>> rtl/core/mic_pkg.sv
`default_nettype none

package mic_pkg;

   localparam int MAX_VERTICES = 4096;
   localparam int IDX_W        = $clog2(MAX_VERTICES);
   localparam int CNT_W        = IDX_W + 1;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   localparam cnt_type CNT_SAT       = {CNT_W{1'b1}};
   localparam cnt_type COUNT_RESET   = CNT_W'(MAX_VERTICES);

endpackage

`default_nettype wire

>>> rtl/core/mic_ram.sv
`default_nettype none

module mic_ram
   import mic_pkg::*;
#(
   parameter int DEPTH = MAX_VERTICES,
   parameter int WIDTH = IDX_W
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/mesh_index_compaction.sv
// An accepted index passes through the forward step and then the decide step, where its
// result is loaded into the output register. Each index makes two dependent reads
// (forward table, then reverse table) before the write-back, and no new index is taken until it is done.
// A result held in the output register by rsp_stall keeps the block waiting in its
// last step, which also stalls the input. Reset is synchronous and active high: it
// empties the output register, zeroes the unique count and sets the count to 4096.
`default_nettype none

module mesh_index_compaction
   import mic_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_stall,
   input  wire idx_type         req_vertex_index,
   input  wire logic            req_start_sub_mesh,
   output      logic            rsp_valid,
   input  wire logic            rsp_stall,
   output      idx_type         rsp_remap_index,
   output      logic            rsp_first_use,
   output      idx_type         rsp_source_vertex,
   output      cnt_type         rsp_unique_count,
   output      logic            rsp_index_error,
   input  wire logic            csr_write_enable,
   input  wire cnt_type         csr_write_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_FWD, ST_REV} state_type;

   state_type state_ff;
   cnt_type   svc_ff;
   cnt_type   count_ff;
   idx_type   idx_ff;
   logic      start_ff;
   logic      err_ff;
   idx_type   fwd_ff;

   logic      rsp_valid_ff;
   idx_type   rsp_remap_index_ff;
   logic      rsp_first_use_ff;
   idx_type   rsp_source_vertex_ff;
   cnt_type   rsp_unique_count_ff;
   logic      rsp_index_error_ff;

   idx_type   fwd_rdata;
   idx_type   rev_rdata;
   idx_type   rev_raddr;
   logic      slot_free;
   logic      finish;
   logic      hit;
   logic      do_write;
   cnt_type   count_eff;
   cnt_type   count_in;

   // The table is a sparse set: an entry is live when its forward value lies below
   // the count and the reverse table points back at the same source index. Garbage
   // in unwritten entries can never pass both tests, so a start only zeroes the count.
   mic_ram #(.DEPTH(MAX_VERTICES), .WIDTH(IDX_W)) u_fwd (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (idx_ff),
      .wr_data (count_eff[IDX_W-1:0]),
      .rd_addr (req_vertex_index),
      .rd_data (fwd_rdata)
   );

   mic_ram #(.DEPTH(MAX_VERTICES), .WIDTH(IDX_W)) u_rev (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (count_eff[IDX_W-1:0]),
      .wr_data (idx_ff),
      .rd_addr (rev_raddr),
      .rd_data (rev_rdata)
   );

   // While the decide step waits on the output, the reverse read keeps its address.
   assign rev_raddr = (state_ff == ST_FWD) ? fwd_rdata : fwd_ff;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign finish    = (state_ff == ST_REV) && slot_free;
   assign count_eff = start_ff ? '0 : count_ff;

   always_comb begin
      hit = 1'b0;
      if ((CNT_W'(fwd_ff) < count_eff) && (rev_rdata == idx_ff)) begin
         hit = 1'b1;
      end
   end

   assign do_write = finish && !err_ff && !hit;

   always_comb begin
      count_in = count_eff;
      if (!err_ff && !hit && (count_eff < CNT_SAT)) begin
         count_in = count_eff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         svc_ff       <= COUNT_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            svc_ff <= csr_write_data;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_FWD;
               end
            end
            ST_FWD: begin
               state_ff <= ST_REV;
            end
            ST_REV: begin
               if (slot_free) begin
                  state_ff             <= ST_IDLE;
                  count_ff             <= count_in;
                  rsp_source_vertex_ff <= idx_ff;
                  rsp_index_error_ff   <= err_ff;
                  rsp_first_use_ff     <= !err_ff && !hit;
                  rsp_unique_count_ff  <= count_in;
                  if (err_ff) begin
                     rsp_remap_index_ff <= '0;
                  end else if (hit) begin
                     rsp_remap_index_ff <= fwd_ff;
                  end else begin
                     rsp_remap_index_ff <= count_eff[IDX_W-1:0];
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req_valid) begin
         idx_ff   <= req_vertex_index;
         start_ff <= req_start_sub_mesh;
         err_ff   <= (CNT_W'(req_vertex_index) >= svc_ff);
      end
      if (state_ff == ST_FWD) begin
         fwd_ff <= fwd_rdata;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_remap_index   = rsp_remap_index_ff;
   assign rsp_first_use     = rsp_first_use_ff;
   assign rsp_source_vertex = rsp_source_vertex_ff;
   assign rsp_unique_count  = rsp_unique_count_ff;
   assign rsp_index_error   = rsp_index_error_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_VERTICES))
      else $error("unique count passed the table depth");

   a_first_dense: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_first_use) |->
         (rsp_remap_index == IDX_W'(rsp_unique_count - CNT_W'(1))))
      else $error("first use did not take the next dense index");

   a_error_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_index_error) |-> (!rsp_first_use && (rsp_remap_index == '0)))
      else $error("an out of range index produced a mapping");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_REV))
      else $error("a result was loaded outside the decide step");
`endif

endmodule

`default_nettype wire

>>> test/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mic_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_CAP     = 50;
   localparam int FULL_SPAN      = 512;

   typedef struct packed {
      idx_type remap_index;
      logic    first_use;
      idx_type source_vertex;
      cnt_type unique_count;
      logic    index_error;
   } remap_result_type;

   typedef enum int {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic    clock              = 1'b0;
   logic    reset              = 1'b1;
   logic    req_valid          = 1'b0;
   logic    req_stall;
   idx_type req_vertex_index   = '0;
   logic    req_start_sub_mesh = 1'b0;
   logic    rsp_valid;
   logic    rsp_stall          = 1'b0;
   idx_type rsp_remap_index;
   logic    rsp_first_use;
   idx_type rsp_source_vertex;
   cnt_type rsp_unique_count;
   logic    rsp_index_error;
   logic    csr_write_enable   = 1'b0;
   cnt_type csr_write_data     = COUNT_RESET;

   // Predictor state: which source vertices have a remap entry in this sub-mesh.
   logic [MAX_VERTICES-1:0] seen_vertices = '0;
   idx_type                 remap_of [MAX_VERTICES];
   cnt_type                 unique_so_far = '0;
   cnt_type                 vertex_limit  = COUNT_RESET;

   remap_result_type pending_remaps [$];

   int mismatch_count     = 0;
   int results_checked    = 0;
   int vertices_sent      = 0;
   int sub_meshes_started = 0;
   int burst_left         = 0;
   int gap_max            = 0;
   int idle_cycles        = 0;

   stall_mode_type stall_mode   = STALL_NONE;
   int             stall_left   = 0;
   int             stall_period = 2;
   int             stall_on     = 1;
   int             stall_tick   = 0;

   mesh_index_compaction i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_vertex_index   (req_vertex_index),
      .req_start_sub_mesh (req_start_sub_mesh),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_remap_index    (rsp_remap_index),
      .rsp_first_use      (rsp_first_use),
      .rsp_source_vertex  (rsp_source_vertex),
      .rsp_unique_count   (rsp_unique_count),
      .rsp_index_error    (rsp_index_error),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic remap_result_type predict_remap(input idx_type vi, input logic st);
      remap_result_type r;
      if (st) begin
         seen_vertices = '0;
         unique_so_far = '0;
      end
      r.remap_index   = '0;
      r.first_use     = 1'b0;
      r.source_vertex = vi;
      r.index_error   = 1'b0;
      if ({1'b0, vi} >= vertex_limit) begin
         r.index_error = 1'b1;
      end else if (seen_vertices[vi]) begin
         r.remap_index = remap_of[vi];
      end else begin
         r.remap_index     = unique_so_far[IDX_W-1:0];
         remap_of[vi]      = unique_so_far[IDX_W-1:0];
         seen_vertices[vi] = 1'b1;
         r.first_use       = 1'b1;
         if (unique_so_far != CNT_SAT) unique_so_far = unique_so_far + cnt_type'(1);
      end
      r.unique_count = unique_so_far;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < REPORT_CAP) $display("MISMATCH: %s", msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string field, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                   results_checked, field, got, want));
   endtask

   // Result checker and receiver stall pattern.
   always @(posedge clock) begin
      remap_result_type want;
      logic             hold;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_remaps.size() == 0) begin
            report_mismatch($sformatf("unexpected result for source vertex %0h",
                                      rsp_source_vertex));
         end else begin
            want = pending_remaps.pop_front();
            check_field("remap_index",   16'(rsp_remap_index),   16'(want.remap_index));
            check_field("first_use",     16'(rsp_first_use),     16'(want.first_use));
            check_field("source_vertex", 16'(rsp_source_vertex), 16'(want.source_vertex));
            check_field("unique_count",  16'(rsp_unique_count),  16'(want.unique_count));
            check_field("index_error",   16'(rsp_index_error),   16'(want.index_error));
         end
         results_checked++;
      end
      if (stall_left == 0) begin
         stall_mode   = stall_mode_type'($urandom_range(0, 3));
         stall_left   = $urandom_range(10, 150);
         stall_period = $urandom_range(2, 24);
         stall_on     = $urandom_range(1, stall_period - 1);
         stall_tick   = 0;
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
         STALL_NONE:  hold = 1'b0;
         STALL_COIN:  hold = ($urandom_range(0, 99) < 50);
         STALL_HEAVY: hold = ($urandom_range(0, 99) < 85);
         default:     hold = ((stall_tick % stall_period) < stall_on);
      endcase
      rsp_stall <= hold;
   end

   // Ends the run when no transfer happens on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles, %0d results still pending",
                  WATCHDOG_LIMIT, pending_remaps.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // The sender works in bursts; a gap is inserted only between bursts.
   task automatic send_vertex(input idx_type vi, input logic st);
      int               gap;
      remap_result_type expected;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid          <= 1'b1;
      req_vertex_index   <= vi;
      req_start_sub_mesh <= st;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected       = predict_remap(vi, st);
      pending_remaps = {pending_remaps, expected};
      vertices_sent++;
      if (st) sub_meshes_started++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_remaps.size() != 0) @(posedge clock);
   endtask

   // The register is only written with the block idle and nothing outstanding.
   task automatic set_vertex_count(input cnt_type value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      vertex_limit = value;
   endtask

   task automatic test_directed_cases();
      gap_max = 0;
      send_vertex(12'h000, 1'b0);
      send_vertex(12'hFFF, 1'b0);
      send_vertex(12'h000, 1'b0);
      send_vertex(12'hFFF, 1'b0);
      // Back-to-back repeats of one vertex check that a lookup sees the entry just written.
      send_vertex(12'h007, 1'b0);
      send_vertex(12'h007, 1'b0);
      send_vertex(12'h007, 1'b0);
      send_vertex(12'hFFF, 1'b1);
      send_vertex(12'h000, 1'b0);
      send_vertex(12'hAAA, 1'b0);
      send_vertex(12'h555, 1'b0);
      set_vertex_count(cnt_type'(1));
      send_vertex(12'h000, 1'b1);
      send_vertex(12'h001, 1'b0);
      send_vertex(12'h000, 1'b0);
      // A start with an out-of-range index still clears the sub-mesh.
      send_vertex(12'h005, 1'b1);
      send_vertex(12'h000, 1'b0);
      send_vertex(12'hFFF, 1'b0);
      set_vertex_count(cnt_type'(0));
      send_vertex(12'h000, 1'b1);
      send_vertex(12'h000, 1'b0);
      set_vertex_count(CNT_SAT);
      send_vertex(12'hFFF, 1'b1);
      send_vertex(12'hFFF, 1'b0);
      set_vertex_count(COUNT_RESET);
      send_vertex(12'hFFE, 1'b0);
      send_vertex(12'hFFF, 1'b0);
   endtask

   // One sub-mesh that uses every vertex below the count, so the unique count meets it.
   task automatic test_full_sub_mesh();
      idx_type order [FULL_SPAN];
      idx_type tmp;
      int      j;
      set_vertex_count(cnt_type'(FULL_SPAN));
      gap_max = 2;
      for (int i = 0; i < FULL_SPAN; i++) order[i] = idx_type'(i);
      for (int i = FULL_SPAN - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < FULL_SPAN; i++) send_vertex(order[i], i == 0);
      send_vertex(order[0], 1'b0);
      send_vertex(order[FULL_SPAN-1], 1'b0);
      set_vertex_count(cnt_type'(FULL_SPAN - 1));
      send_vertex(idx_type'(FULL_SPAN - 1), 1'b0);
   endtask

   task automatic test_random_sub_meshes(input int item_goal);
      cnt_type limit;
      int      quota;
      int      sent;
      int      length;
      int      pool_size;
      int      hi;
      int      pick;
      idx_type pool [32];
      idx_type vi;
      idx_type last_vi;
      logic    st;
      last_vi = '0;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       limit = COUNT_RESET;
            1:       limit = CNT_SAT;
            2:       limit = cnt_type'(1);
            3:       limit = cnt_type'(16);
            4:       limit = cnt_type'(0);
            5:       limit = cnt_type'($urandom_range(2, MAX_VERTICES - 1));
            6:       limit = cnt_type'($urandom_range(MAX_VERTICES + 1, 8190));
            default: limit = COUNT_RESET;
         endcase
         quota   = (limit == 0) ? 30 : item_goal / 7;
         gap_max = (phase % 3 == 1) ? 0 : ((phase % 3 == 2) ? 20 : 5);
         set_vertex_count(limit);
         hi   = (limit == 0 || limit > MAX_VERTICES) ? MAX_VERTICES - 1 : int'(limit) - 1;
         sent = 0;
         while (sent < quota) begin
            length    = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                                    : $urandom_range(1, 40);
            pool_size = $urandom_range(1, 32);
            for (int k = 0; k < pool_size; k++) pool[k] = idx_type'($urandom_range(0, hi));
            for (int n = 0; n < length && sent < quota; n++) begin
               pick = $urandom_range(0, 99);
               if (pick < 6)
                  vi = idx_type'($urandom_range(0, MAX_VERTICES - 1));
               else if (pick < 16 && n > 0)
                  vi = last_vi;
               else
                  vi = pool[$urandom_range(0, pool_size - 1)];
               // Now and then a stray start breaks a sub-mesh in the middle.
               st = (n == 0) || ($urandom_range(0, 99) < 2);
               send_vertex(vi, st);
               last_vi = vi;
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_full_sub_mesh();
      test_random_sub_meshes(770);
      drain_results();
      repeat (12) @(posedge clock);
      $display("Checked %0d results for %0d vertex indices in %0d sub-meshes.",
               results_checked, vertices_sent, sub_meshes_started);
      $display("Source vertex counts ran from 0 to 8191, with one sub-mesh that filled its count.");
      if (mismatch_count == 0 && pending_remaps.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> mesh_index_compaction.f
rtl/core/mic_pkg.sv
rtl/core/mic_ram.sv
rtl/core/mesh_index_compaction.sv
test/tb_top.sv
